>>> rtl/acf_pkg.sv
// ----------------------------------------------------------------------------
// acf_pkg
// Types, constants and codes shared by the attitude complementary filter.
// ----------------------------------------------------------------------------
package acf_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int DIV_W        = SAMPLE_WIDTH + 10;  // widest dividend (blend)
   localparam int GYRO_DIV_W   = SAMPLE_WIDTH + 2;   // gyro accumulator sum
   localparam int DEN_W        = 10;
   localparam int CNT_W        = $clog2(DIV_W + 1);
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 10;

   localparam int SMOOTH_DEN   = 20;
   localparam int CLAMP_WIN    = 10;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_RATE_DIVISOR    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ACCEL_SMOOTHING = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ACCEL_WEIGHT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GYRO_WEIGHT     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SLOW_RATIO      = 3'd4;

   localparam logic [9:0] RATE_DIVISOR_RST    = 10'd16;
   localparam logic [4:0] ACCEL_SMOOTHING_RST = 5'd10;
   localparam logic [7:0] ACCEL_WEIGHT_RST    = 8'd1;
   localparam logic [7:0] GYRO_WEIGHT_RST     = 8'd9;
   localparam logic [7:0] SLOW_RATIO_RST      = 8'd4;

   localparam logic signed [SAMPLE_WIDTH-1:0] GYRO_OFF_RST [3] = '{
      SAMPLE_WIDTH'(16), SAMPLE_WIDTH'(42), SAMPLE_WIDTH'(0)};
   localparam logic signed [SAMPLE_WIDTH-1:0] ACCEL_OFF_RST [3] = '{
      SAMPLE_WIDTH'(38), SAMPLE_WIDTH'(-4), SAMPLE_WIDTH'(470)};

   // divider operation kinds
   localparam logic [1:0] KIND_GYRO  = 2'd0;
   localparam logic [1:0] KIND_FILT  = 2'd1;
   localparam logic [1:0] KIND_BLEND = 2'd2;

   typedef struct packed {
      logic                           action;
      logic signed [SAMPLE_WIDTH-1:0] gyro_x;
      logic signed [SAMPLE_WIDTH-1:0] gyro_y;
      logic signed [SAMPLE_WIDTH-1:0] gyro_z;
      logic signed [SAMPLE_WIDTH-1:0] accel_x;
      logic signed [SAMPLE_WIDTH-1:0] accel_y;
      logic signed [SAMPLE_WIDTH-1:0] accel_z;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] angle_a;
      logic signed [SAMPLE_WIDTH-1:0] angle_b;
      logic signed [SAMPLE_WIDTH-1:0] yaw_step;
      logic signed [SAMPLE_WIDTH-1:0] rate_a;
      logic signed [SAMPLE_WIDTH-1:0] rate_b;
      logic signed [SAMPLE_WIDTH-1:0] rate_c;
      logic                           blended;
      logic                           captured;
   } rsp_type;

   typedef struct packed {
      logic       latch;
      logic       capture;
      logic       div_start;
      logic [1:0] kind;
      logic [1:0] idx;
      logic       div_store;
      logic       pace;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic blend_go;
      logic wsum_zero;
      logic capture_item;
   } sts_type;

endpackage

>>> rtl/acf_div.sv
// ----------------------------------------------------------------------------
// acf_div
// Shared signed divider, restoring, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module acf_div
   import acf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    short_mode,
   input  logic signed [DIV_W-1:0] num,
   input  logic [DEN_W-1:0]        den,
   output logic                    done,
   output logic signed [DIV_W-1:0] quot,
   output logic signed [DIV_W-1:0] drem
);

   logic [DIV_W-1:0] mag;
   logic [DIV_W-1:0] a_ff, a_in, q_ff, q_in;
   logic [DEN_W-1:0] r_ff, r_in, den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, neg_ff, neg_in;
   logic [DEN_W:0]   rs, rs_sub;

   assign mag    = num[DIV_W-1] ? DIV_W'(-num) : DIV_W'(num);
   assign rs     = {r_ff, a_ff[DIV_W-1]};
   assign rs_sub = rs - {1'b0, den_ff};
   assign done   = busy_ff && (cnt_ff == '0);
   assign quot   = neg_ff ? -$signed(q_ff) : $signed(q_ff);
   assign drem   = neg_ff ? -$signed(DIV_W'(r_ff)) : $signed(DIV_W'(r_ff));

   always_comb begin
      a_in    = a_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      if (start) begin
         // short operands are pre-aligned so only their bits are iterated
         a_in    = short_mode ? (mag << (DIV_W - GYRO_DIV_W)) : mag;
         q_in    = '0;
         r_in    = '0;
         den_in  = den;
         cnt_in  = short_mode ? CNT_W'(GYRO_DIV_W) : CNT_W'(DIV_W);
         busy_in = 1'b1;
         neg_in  = num[DIV_W-1];
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            a_in   = a_ff << 1;
            cnt_in = cnt_ff - 1'b1;
            if (!rs_sub[DEN_W]) begin
               r_in = rs_sub[DEN_W-1:0];
               q_in = {q_ff[DIV_W-2:0], 1'b1};
            end else begin
               r_in = rs[DEN_W-1:0];
               q_in = {q_ff[DIV_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

>>> rtl/acf_datapath.sv
// ----------------------------------------------------------------------------
// acf_datapath
// Filter state, configuration registers, operand selection and result register.
// ----------------------------------------------------------------------------
module acf_datapath
   import acf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  req_type               req_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  cmd_type               cmd,
   output sts_type               sts,
   output rsp_type               rsp_data
);

   localparam int SW = SAMPLE_WIDTH;
   // ceil(2^24 / 5): exact divide by 5 for operands below 2^22
   localparam logic [21:0] RECIP5 = 22'd3355444;

   logic [9:0] rate_div_ff;
   logic [4:0] smooth_ff;
   logic [7:0] aw_ff, gw_ff, slow_ff, pace_ff;

   req_type                 in_ff;
   rsp_type                 rsp_ff;
   logic signed [SW-1:0]    goff_ff [3];
   logic signed [SW-1:0]    aoff_ff [3];
   logic signed [SW-1:0]    rem_ff  [3];
   logic signed [SW-1:0]    rate_ff [3];
   logic signed [SW-1:0]    ang_ff  [2];
   logic signed [SW-1:0]    filt_ff [2];
   logic signed [DIV_W-1:0] fc_ff   [2];
   logic signed [DIV_W-1:0] fnum_ff;
   logic                    blended_ff, captured_ff;

   logic signed [SW-1:0]    g_sel, off_sel, facc, foff;
   logic signed [SW:0]      d_raw, d_db, a_delta;
   logic signed [SW+1:0]    g_sum;
   logic [4:0]              s_sat, s_new;
   logic [8:0]              wsum;
   logic [7:0]              pace_n;
   logic signed [DIV_W-1:0] num, quot, drem, fval, center, clamped;
   logic [DEN_W-1:0]        den;
   logic                    div_done;
   logic [DIV_W-1:0]        fmag, fq;
   logic [45:0]             fprod;
   logic signed [DIV_W-1:0] fquot;

   assign s_sat  = (smooth_ff > 5'(SMOOTH_DEN)) ? 5'(SMOOTH_DEN) : smooth_ff;
   assign s_new  = 5'(SMOOTH_DEN) - s_sat;
   assign wsum   = {1'b0, aw_ff} + {1'b0, gw_ff};
   assign pace_n = pace_ff + 8'd1;

   always_comb begin
      case (cmd.idx)
         2'd0: begin g_sel = in_ff.gyro_x; off_sel = goff_ff[0]; end
         2'd1: begin g_sel = in_ff.gyro_y; off_sel = goff_ff[1]; end
         default: begin g_sel = in_ff.gyro_z; off_sel = goff_ff[2]; end
      endcase
   end

   assign d_raw = (SW+1)'(g_sel) - (SW+1)'(off_sel);
   assign d_db  = (d_raw >= -1 && d_raw <= 1) ? '0 : d_raw;
   assign g_sum = (SW+2)'(rem_ff[cmd.idx]) + (SW+2)'(d_db);

   assign facc    = cmd.idx[0] ? in_ff.accel_y : in_ff.accel_x;
   assign foff    = aoff_ff[cmd.idx[0]];
   assign a_delta = (SW+1)'(facc) - (SW+1)'(foff);

   always_comb begin
      case (cmd.kind)
         KIND_GYRO: begin
            num = DIV_W'(g_sum);
            den = (rate_div_ff == '0) ? DEN_W'(1) : rate_div_ff;
         end
         KIND_FILT: begin
            num = DIV_W'($signed({1'b0, s_sat})) * DIV_W'(filt_ff[cmd.idx[0]])
                + DIV_W'($signed({1'b0, s_new})) * DIV_W'(a_delta);
            den = DEN_W'(SMOOTH_DEN);
         end
         default: begin
            num = DIV_W'($signed({1'b0, aw_ff})) * fc_ff[~cmd.idx[0]]
                + DIV_W'($signed({1'b0, gw_ff})) * DIV_W'(ang_ff[cmd.idx[0]]);
            den = DEN_W'(wsum);
         end
      endcase
   end

   acf_div u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (cmd.div_start && cmd.kind != KIND_FILT),
      .short_mode (cmd.kind == KIND_GYRO),
      .num        (num),
      .den        (den),
      .done       (div_done),
      .quot       (quot),
      .drem       (drem)
   );

   // smoothing divide by 20: drop two bits, then reciprocal multiply by 1/5
   assign fmag  = fnum_ff[DIV_W-1] ? DIV_W'(-fnum_ff) : DIV_W'(fnum_ff);
   assign fprod = 46'(fmag[DIV_W-1:2]) * 46'(RECIP5);
   assign fq    = DIV_W'(fprod[45:24]);
   assign fquot = fnum_ff[DIV_W-1] ? -$signed(fq) : $signed(fq);

   // filtered accel X is negated; each axis is held near the opposite angle
   assign fval    = cmd.idx[0] ? fquot : -fquot;
   assign center  = DIV_W'(ang_ff[~cmd.idx[0]]);
   assign clamped = (fval > center + DIV_W'(CLAMP_WIN)) ? center + DIV_W'(CLAMP_WIN) :
                    (fval < center - DIV_W'(CLAMP_WIN)) ? center - DIV_W'(CLAMP_WIN) : fval;

   assign sts.div_done     = div_done;
   assign sts.blend_go     = (pace_n == slow_ff);
   assign sts.wsum_zero    = (wsum == '0);
   assign sts.capture_item = in_ff.action;
   assign rsp_data         = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_div_ff <= RATE_DIVISOR_RST;
         smooth_ff   <= ACCEL_SMOOTHING_RST;
         aw_ff       <= ACCEL_WEIGHT_RST;
         gw_ff       <= GYRO_WEIGHT_RST;
         slow_ff     <= SLOW_RATIO_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_RATE_DIVISOR:    rate_div_ff <= csr_wdata[9:0];
            REG_ACCEL_SMOOTHING: smooth_ff   <= csr_wdata[4:0];
            REG_ACCEL_WEIGHT:    aw_ff       <= csr_wdata[7:0];
            REG_GYRO_WEIGHT:     gw_ff       <= csr_wdata[7:0];
            REG_SLOW_RATIO:      slow_ff     <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         in_ff <= req_data;
      end
      if (cmd.out_load) begin
         rsp_ff <= '{angle_a: ang_ff[0], angle_b: ang_ff[1], yaw_step: rate_ff[2],
                     rate_a: rate_ff[0], rate_b: rate_ff[1], rate_c: rate_ff[2],
                     blended: blended_ff, captured: captured_ff};
      end
      if (cmd.div_start && cmd.kind == KIND_FILT) begin
         fnum_ff <= num;
      end
      if (cmd.div_store && cmd.kind == KIND_FILT) begin
         fc_ff[cmd.idx[0]] <= clamped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            goff_ff[i] <= GYRO_OFF_RST[i];
            aoff_ff[i] <= ACCEL_OFF_RST[i];
            rem_ff[i]  <= '0;
            rate_ff[i] <= '0;
         end
         for (int i = 0; i < 2; i++) begin
            ang_ff[i]  <= '0;
            filt_ff[i] <= '0;
         end
         pace_ff     <= '0;
         blended_ff  <= 1'b0;
         captured_ff <= 1'b0;
      end else begin
         if (cmd.latch) begin
            for (int i = 0; i < 3; i++) rate_ff[i] <= '0;
            blended_ff  <= 1'b0;
            captured_ff <= 1'b0;
         end
         if (cmd.capture) begin
            goff_ff[0]  <= in_ff.gyro_x;
            goff_ff[1]  <= in_ff.gyro_y;
            goff_ff[2]  <= in_ff.gyro_z;
            aoff_ff[0]  <= in_ff.accel_x;
            aoff_ff[1]  <= in_ff.accel_y;
            aoff_ff[2]  <= in_ff.accel_z;
            captured_ff <= 1'b1;
         end
         if (cmd.pace) begin
            pace_ff    <= sts.blend_go ? 8'd0 : pace_n;
            blended_ff <= sts.blend_go;
         end
         if (cmd.div_store) begin
            case (cmd.kind)
               KIND_GYRO: begin
                  rate_ff[cmd.idx] <= quot[SW-1:0];
                  rem_ff[cmd.idx]  <= drem[SW-1:0];
                  if (cmd.idx != 2'd2) begin
                     ang_ff[cmd.idx[0]] <= ang_ff[cmd.idx[0]] + quot[SW-1:0];
                  end
               end
               KIND_FILT: filt_ff[cmd.idx[0]] <= clamped[SW-1:0];
               default:   ang_ff[cmd.idx[0]]  <= quot[SW-1:0];
            endcase
         end
      end
   end

endmodule

>>> rtl/acf_ctrl.sv
// ----------------------------------------------------------------------------
// acf_ctrl
// Sequencer: walks each item through the divider operations and the handshakes.
// ----------------------------------------------------------------------------
module acf_ctrl
   import acf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CAP   = 4'd1;
   localparam logic [3:0] ST_GLOAD = 4'd2;
   localparam logic [3:0] ST_GWAIT = 4'd3;
   localparam logic [3:0] ST_PACE  = 4'd4;
   localparam logic [3:0] ST_FLOAD = 4'd5;
   localparam logic [3:0] ST_FWAIT = 4'd6;
   localparam logic [3:0] ST_BLOAD = 4'd7;
   localparam logic [3:0] ST_BWAIT = 4'd8;
   localparam logic [3:0] ST_FIN   = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic       out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = valid_ff;
   assign out_free  = !valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      valid_in = (valid_ff && !rsp_ready);
      cmd      = '0;
      cmd.idx  = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               idx_in    = 2'd0;
               state_in  = ST_CAP;
            end
         end
         ST_CAP: begin
            // latched action picks the path; capture skips the divider
            cmd.kind = KIND_GYRO;
            if (sts.capture_item) begin
               cmd.capture = 1'b1;
               state_in    = ST_FIN;
            end else begin
               state_in    = ST_GLOAD;
            end
         end
         ST_GLOAD: begin
            cmd.kind      = KIND_GYRO;
            cmd.div_start = 1'b1;
            state_in      = ST_GWAIT;
         end
         ST_GWAIT: begin
            cmd.kind = KIND_GYRO;
            if (sts.div_done) begin
               cmd.div_store = 1'b1;
               if (idx_ff == 2'd2) begin
                  state_in = ST_PACE;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = ST_GLOAD;
               end
            end
         end
         ST_PACE: begin
            cmd.pace = 1'b1;
            idx_in   = 2'd0;
            state_in = sts.blend_go ? ST_FLOAD : ST_FIN;
         end
         ST_FLOAD: begin
            cmd.kind      = KIND_FILT;
            cmd.div_start = 1'b1;
            state_in      = ST_FWAIT;
         end
         ST_FWAIT: begin
            cmd.kind      = KIND_FILT;
            cmd.div_store = 1'b1;
            if (idx_ff == 2'd1) begin
               idx_in   = 2'd0;
               state_in = sts.wsum_zero ? ST_FIN : ST_BLOAD;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = ST_FLOAD;
            end
         end
         ST_BLOAD: begin
            cmd.kind      = KIND_BLEND;
            cmd.div_start = 1'b1;
            state_in      = ST_BWAIT;
         end
         ST_BWAIT: begin
            cmd.kind = KIND_BLEND;
            if (sts.div_done) begin
               cmd.div_store = 1'b1;
               if (idx_ff == 2'd1) begin
                  state_in = ST_FIN;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = ST_BLOAD;
               end
            end
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               valid_in     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

endmodule

>>> rtl/attitude_complementary_filter_top.sv
// ----------------------------------------------------------------------------
// attitude_complementary_filter_top
// Gyro integration blended with an accelerometer tilt estimate.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_data  (req_type)
//   rsp      out        rsp_valid/rsp_ready    rsp_data  (rsp_type)
//   csr      in         csr_we                 csr_index, csr_wdata
//
// Capture item: skips the divider. Filter tick: three serial gyro
// divisions on the shared divider. A blend tick adds two smoothing steps
// and two blend divisions; the blend divisions are skipped when both
// weights are zero.
// One item at a time; a new item is taken while the last result waits.
// Synchronous reset restores registers, offsets and filter state.
// ----------------------------------------------------------------------------
module attitude_complementary_filter_top
   import acf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   acf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   acf_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/acf_checker.sv
// ----------------------------------------------------------------------------
// acf_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module acf_checker
   import acf_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped or changed while stalled");

   a_cap_no_blend: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.captured && rsp_data.blended))
      else $error("capture item reports a blend");

   a_cap_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.captured |-> rsp_data.rate_a == '0 &&
         rsp_data.rate_b == '0 && rsp_data.rate_c == '0 && rsp_data.yaw_step == '0)
      else $error("capture item reports nonzero rates");

   a_yaw_rate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.yaw_step == rsp_data.rate_c)
      else $error("yaw step differs from axis 2 rate");

endmodule

bind attitude_complementary_filter_top acf_checker u_acf_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
